### src/button_page_selector_macros.svh
// ----------------------------------------------------------------------------
// button_page_selector_macros
// Assertion macros used by the button page selector top level.
// Each macro expands to one labelled concurrent assertion, sampled on the
// rising clock edge and switched off while reset is high.
// ----------------------------------------------------------------------------
`ifndef BUTTON_PAGE_SELECTOR_MACROS_SVH
`define BUTTON_PAGE_SELECTOR_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold at that edge.
`define BPS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication: when ante holds, cons must hold at the next edge.
`define BPS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/bps_pkg.sv
// ----------------------------------------------------------------------------
// bps_pkg
// Types and constants shared by the button page selector modules.
// ----------------------------------------------------------------------------
`default_nettype none

package bps_pkg;

   // Widths
   localparam int unsigned TimeWidth  = 32;
   localparam int unsigned PageWidth  = 3;
   localparam int unsigned CountWidth = 3;
   localparam int unsigned CsrIdxWidth  = 3;
   localparam int unsigned CsrDataWidth = 32;

   // Last page index the display supports
   localparam logic [3:0] LastPage = 4'd7;

   // Register indexes of the configuration port
   localparam logic [CsrIdxWidth-1:0] CsrDisplayEnabled = 3'd0;
   localparam logic [CsrIdxWidth-1:0] CsrDisplayReady   = 3'd1;
   localparam logic [CsrIdxWidth-1:0] CsrPageInterval   = 3'd2;
   localparam logic [CsrIdxWidth-1:0] CsrPageCount      = 3'd3;
   localparam logic [CsrIdxWidth-1:0] CsrDebounce       = 3'd4;
   localparam logic [CsrIdxWidth-1:0] CsrClickWindow    = 3'd5;
   localparam logic [CsrIdxWidth-1:0] CsrClickTarget    = 3'd6;
   localparam logic [CsrIdxWidth-1:0] CsrSpecialHold    = 3'd7;

   // Register reset values
   localparam logic [31:0] RstPageInterval = 32'd5000;
   localparam logic [3:0]  RstPageCount    = 4'd8;
   localparam logic [15:0] RstDebounce     = 16'd40;
   localparam logic [15:0] RstClickWindow  = 16'd2500;
   localparam logic [2:0]  RstClickTarget  = 3'd5;
   localparam logic [15:0] RstSpecialHold  = 16'd5000;

   // Configuration registers
   typedef struct packed {
      logic        display_enabled;
      logic        display_ready;
      logic [31:0] page_interval_ms;
      logic [3:0]  page_count;
      logic [15:0] debounce_ms;
      logic [15:0] click_window_ms;
      logic [2:0]  click_target;
      logic [15:0] special_hold_ms;
   } cfg_type;

   // Selector state carried from one sample to the next
   typedef struct packed {
      logic                  button_last_pressed;
      logic [TimeWidth-1:0]  button_changed_time;
      logic                  press_handled;
      logic [CountWidth-1:0] fast_click_count;
      logic [TimeWidth-1:0]  click_window_start;
      logic                  special_active;
      logic [TimeWidth-1:0]  special_until;
      logic                  page_sequence_on;
      logic [PageWidth-1:0]  current_page;
      logic [TimeWidth-1:0]  page_shown_time;
      logic [TimeWidth-1:0]  last_refresh_time;
      logic                  first_main_pending;
   } state_type;

   // One result item
   typedef struct packed {
      logic                 redraw;
      logic [PageWidth-1:0] page_index;
      logic                 special_shown;
      logic                 sequence_active;
   } result_type;

   localparam state_type StateReset = '{
      button_last_pressed: 1'b0,
      button_changed_time: '0,
      press_handled:       1'b0,
      fast_click_count:    '0,
      click_window_start:  '0,
      special_active:      1'b0,
      special_until:       '0,
      page_sequence_on:    1'b0,
      current_page:        '0,
      page_shown_time:     '0,
      last_refresh_time:   '0,
      first_main_pending:  1'b1
   };

endpackage

`default_nettype wire

### src/bps_csr.sv
// ----------------------------------------------------------------------------
// bps_csr
// Configuration register file of the button page selector; write only.
// ----------------------------------------------------------------------------
`default_nettype none

module bps_csr (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_write_enable,
   input  wire logic [bps_pkg::CsrIdxWidth-1:0]   csr_index,
   input  wire logic [bps_pkg::CsrDataWidth-1:0]  csr_write_data,
   output      bps_pkg::cfg_type                  cfg
);

   bps_pkg::cfg_type cfg_ff;
   bps_pkg::cfg_type cfg_in;

   // Decode the write onto the addressed register, truncating to its width
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            bps_pkg::CsrDisplayEnabled: cfg_in.display_enabled  = csr_write_data[0];
            bps_pkg::CsrDisplayReady:   cfg_in.display_ready    = csr_write_data[0];
            bps_pkg::CsrPageInterval:   cfg_in.page_interval_ms = csr_write_data[31:0];
            bps_pkg::CsrPageCount:      cfg_in.page_count       = csr_write_data[3:0];
            bps_pkg::CsrDebounce:       cfg_in.debounce_ms      = csr_write_data[15:0];
            bps_pkg::CsrClickWindow:    cfg_in.click_window_ms  = csr_write_data[15:0];
            bps_pkg::CsrClickTarget:    cfg_in.click_target     = csr_write_data[2:0];
            bps_pkg::CsrSpecialHold:    cfg_in.special_hold_ms  = csr_write_data[15:0];
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   // Hold the registers; reset to their power-on values
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.display_enabled  <= 1'b1;
         cfg_ff.display_ready    <= 1'b0;
         cfg_ff.page_interval_ms <= bps_pkg::RstPageInterval;
         cfg_ff.page_count       <= bps_pkg::RstPageCount;
         cfg_ff.debounce_ms      <= bps_pkg::RstDebounce;
         cfg_ff.click_window_ms  <= bps_pkg::RstClickWindow;
         cfg_ff.click_target     <= bps_pkg::RstClickTarget;
         cfg_ff.special_hold_ms  <= bps_pkg::RstSpecialHold;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

### src/bps_step.sv
// ----------------------------------------------------------------------------
// bps_step
// Next-state and result logic for one button sample.
// ----------------------------------------------------------------------------
`default_nettype none

module bps_step (
   input  wire bps_pkg::cfg_type                    cfg,
   input  wire bps_pkg::state_type                  state_cur,
   input  wire logic [bps_pkg::TimeWidth-1:0]       now_ms,
   input  wire logic                                button_pressed,
   output      bps_pkg::state_type                  state_nxt,
   output      bps_pkg::result_type                 result
);

   logic [bps_pkg::TimeWidth-1:0]  hold_left;
   logic                           held;
   logic [bps_pkg::TimeWidth-1:0]  since_change;
   logic [bps_pkg::TimeWidth-1:0]  since_window;
   logic [bps_pkg::TimeWidth-1:0]  since_shown;
   logic [bps_pkg::TimeWidth-1:0]  since_refresh;
   logic                           level_changed;
   logic                           press_fire;
   logic                           special_start;
   logic [bps_pkg::CountWidth-1:0] count_nxt;
   logic [3:0]                     page_adv;
   logic                           redraw;
   bps_pkg::state_type             s;

   // Special screen still held while the signed time left is positive
   assign hold_left = state_cur.special_until - now_ms;
   assign held      = state_cur.special_active && (hold_left != '0) && !hold_left[31];

   assign level_changed = button_pressed != state_cur.button_last_pressed;
   assign since_change  = level_changed ? '0 : (now_ms - state_cur.button_changed_time);
   assign since_window  = now_ms - state_cur.click_window_start;
   assign press_fire    = button_pressed && !state_cur.press_handled &&
                          (since_change >= {16'd0, cfg.debounce_ms});

   // Count fast clicks, restarting the window when it has run out
   always_comb begin
      if ((state_cur.fast_click_count == '0) ||
          (since_window > {16'd0, cfg.click_window_ms})) begin
         count_nxt = 3'd1;
      end else begin
         count_nxt = state_cur.fast_click_count + 3'd1;
      end
   end

   assign special_start = press_fire && (count_nxt >= cfg.click_target);

   // Walk one sample through the selector
   always_comb begin
      s             = state_cur;
      redraw        = 1'b0;
      page_adv      = '0;
      since_shown   = '0;
      since_refresh = '0;
      if (cfg.display_enabled && cfg.display_ready && !held) begin
         // Expired special screen: back to main
         if (state_cur.special_active) begin
            s.special_active    = 1'b0;
            s.current_page      = '0;
            s.page_sequence_on  = 1'b0;
            s.last_refresh_time = now_ms;
            redraw              = 1'b1;
         end

         // Track level changes for debouncing
         if (level_changed) begin
            s.button_changed_time = now_ms;
            s.button_last_pressed = button_pressed;
         end

         if (press_fire) begin
            s.press_handled = 1'b1;
            if (count_nxt != 3'd1 || state_cur.fast_click_count != '0 ||
                since_window <= {16'd0, cfg.click_window_ms}) begin
               s.fast_click_count = count_nxt;
            end
            if ((state_cur.fast_click_count == '0) ||
                (since_window > {16'd0, cfg.click_window_ms})) begin
               s.click_window_start = now_ms;
               s.fast_click_count   = 3'd1;
            end
         end

         if (special_start) begin
            // Enter special screen and stop here
            s.fast_click_count = '0;
            s.special_active   = 1'b1;
            s.special_until    = now_ms + {16'd0, cfg.special_hold_ms};
            s.page_sequence_on = 1'b0;
            s.current_page     = '0;
            redraw             = 1'b1;
         end else begin
            // Advance one page per press
            if (press_fire) begin
               if (!s.page_sequence_on) begin
                  s.page_sequence_on = 1'b1;
                  s.current_page     = 3'd1;
               end else begin
                  page_adv = {1'b0, s.current_page} + 4'd1;
                  if ((page_adv >= cfg.page_count) || (page_adv > bps_pkg::LastPage)) begin
                     s.current_page     = '0;
                     s.page_sequence_on = 1'b0;
                  end else begin
                     s.current_page = page_adv[2:0];
                  end
               end
               s.page_shown_time   = now_ms;
               s.last_refresh_time = now_ms;
               redraw              = 1'b1;
            end

            // Release re-arms the press
            if (!button_pressed) begin
               s.press_handled = 1'b0;
            end

            // Extra page timed out
            since_shown = now_ms - s.page_shown_time;
            if (s.page_sequence_on && (since_shown >= cfg.page_interval_ms)) begin
               s.current_page      = '0;
               s.page_sequence_on  = 1'b0;
               s.last_refresh_time = now_ms;
               redraw              = 1'b1;
            end

            // Periodic or first render of the main page
            since_refresh = now_ms - s.last_refresh_time;
            if (!s.page_sequence_on &&
                (s.first_main_pending || (since_refresh >= cfg.page_interval_ms))) begin
               s.first_main_pending = 1'b0;
               s.last_refresh_time  = now_ms;
               s.current_page       = '0;
               redraw               = 1'b1;
            end
         end
      end
   end

   assign state_nxt              = s;
   assign result.redraw          = redraw;
   assign result.page_index      = s.current_page;
   assign result.special_shown   = s.special_active;
   assign result.sequence_active = s.page_sequence_on;

endmodule

`default_nettype wire

### src/button_page_selector.sv
// ----------------------------------------------------------------------------
// button_page_selector
// Debounced push-button page selector with timed return and special screen.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake              Contents
//   req_     in         req_valid / req_ready  now_ms, button_pressed
//   rsp_     out        rsp_valid / rsp_ready  redraw, page_index, special_shown,
//                                              sequence_active
//   csr_     in         csr_write_enable       csr_index, csr_write_data
//
// Every sample gives exactly one result; it passes through the input register
// and then the result register.
// One sample per cycle is sustained while rsp_ready stays high; the state update
// for a sample happens as its result enters the result register.
// A stalled result holds the result register; the input register still takes
// one more sample, then req_ready drops until the result is taken.
// Synchronous active-high reset clears both stages and the selector state.
// ----------------------------------------------------------------------------
`default_nettype none

`include "button_page_selector_macros.svh"

module button_page_selector (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output      logic                              req_ready,
   input  wire logic [bps_pkg::TimeWidth-1:0]     req_now_ms,
   input  wire logic                              req_button_pressed,
   output      logic                              rsp_valid,
   input  wire logic                              rsp_ready,
   output      logic                              rsp_redraw,
   output      logic [bps_pkg::PageWidth-1:0]     rsp_page_index,
   output      logic                              rsp_special_shown,
   output      logic                              rsp_sequence_active,
   input  wire logic                              csr_write_enable,
   input  wire logic [bps_pkg::CsrIdxWidth-1:0]   csr_index,
   input  wire logic [bps_pkg::CsrDataWidth-1:0]  csr_write_data
);

   bps_pkg::cfg_type              cfg;
   bps_pkg::state_type            state_ff;
   bps_pkg::state_type            state_in;
   bps_pkg::result_type           result_ff;
   bps_pkg::result_type           result_in;
   logic                          in_valid_ff;
   logic [bps_pkg::TimeWidth-1:0] in_now_ff;
   logic                          in_pressed_ff;
   logic                          out_valid_ff;
   logic                          advance;

   bps_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   bps_step u_step (
      .cfg            (cfg),
      .state_cur      (state_ff),
      .now_ms         (in_now_ff),
      .button_pressed (in_pressed_ff),
      .state_nxt      (state_in),
      .result         (result_in)
   );

   // Move the held sample on when the result register is free
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_now_ff     <= req_now_ms;
         in_pressed_ff <= req_button_pressed;
      end
   end

   // Selector state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bps_pkg::StateReset;
         out_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            state_ff <= state_in;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_redraw          = result_ff.redraw;
   assign rsp_page_index      = result_ff.page_index;
   assign rsp_special_shown   = result_ff.special_shown;
   assign rsp_sequence_active = result_ff.sequence_active;

   // Checks
   `BPS_ASSERT_NOW(a_special_on_main, clock, reset, rsp_valid && rsp_special_shown, (rsp_page_index == '0) && !rsp_sequence_active, "special screen reported off the main page")
   `BPS_ASSERT_NOW(a_sequence_off_main, clock, reset, rsp_valid && rsp_sequence_active, rsp_page_index != '0, "page sequence reported on the main page")
   `BPS_ASSERT_NOW(a_special_clears_clicks, clock, reset, state_ff.special_active, (state_ff.fast_click_count == '0) && !state_ff.page_sequence_on, "click count or page sequence live during special screen")
   `BPS_ASSERT_NEXT(a_stall_freezes_state, clock, reset, out_valid_ff && !rsp_ready, $stable(state_ff), "selector state moved while the result was stalled")

endmodule

`default_nettype wire

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the button page selector.
// Drives timestamped button samples through the request channel and predicts
// every screen update in a scoreboard. Each returned update is compared with
// the oldest prediction. Configuration is rewritten between phases, and both
// channels stall at random.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bps_pkg::*;

   // Screen predictor and store of expected screen updates
   class page_scoreboard;
      cfg_type    cfg;
      state_type  st;
      result_type expected_screens[$];
      int unsigned mismatches;
      int unsigned screens_seen;

      function new();
         cfg.display_enabled  = 1'b1;
         cfg.display_ready    = 1'b0;
         cfg.page_interval_ms = RstPageInterval;
         cfg.page_count       = RstPageCount;
         cfg.debounce_ms      = RstDebounce;
         cfg.click_window_ms  = RstClickWindow;
         cfg.click_target     = RstClickTarget;
         cfg.special_hold_ms  = RstSpecialHold;
         st           = StateReset;
         mismatches   = 0;
         screens_seen = 0;
      endfunction

      function void write_reg(logic [CsrIdxWidth-1:0] idx, logic [CsrDataWidth-1:0] data);
         case (idx)
            CsrDisplayEnabled: cfg.display_enabled  = data[0];
            CsrDisplayReady:   cfg.display_ready    = data[0];
            CsrPageInterval:   cfg.page_interval_ms = data;
            CsrPageCount:      cfg.page_count       = data[3:0];
            CsrDebounce:       cfg.debounce_ms      = data[15:0];
            CsrClickWindow:    cfg.click_window_ms  = data[15:0];
            CsrClickTarget:    cfg.click_target     = data[2:0];
            CsrSpecialHold:    cfg.special_hold_ms  = data[15:0];
            default: ;
         endcase
      endfunction

      function result_type shown_screen(logic redraw);
         result_type r;
         r.redraw          = redraw;
         r.page_index      = st.current_page;
         r.special_shown   = st.special_active;
         r.sequence_active = st.page_sequence_on;
         return r;
      endfunction

      function int unsigned pending();
         return expected_screens.size();
      endfunction

      // Note an accepted sample and predict the screen it leads to
      function void note_sample(logic [TimeWidth-1:0] now, logic pressed);
         logic                 redraw;
         logic [3:0]           next_page;
         logic [TimeWidth-1:0] left;
         redraw = 1'b0;

         // Display off or not ready: report the current screen, change nothing
         if (!(cfg.display_enabled && cfg.display_ready)) begin
            expected_screens.push_back(shown_screen(1'b0));
            return;
         end

         // Special screen: ignore input while held, redraw main once it runs out
         if (st.special_active) begin
            left = st.special_until - now;
            if (left != '0 && !left[TimeWidth-1]) begin
               expected_screens.push_back(shown_screen(1'b0));
               return;
            end
            st.special_active    = 1'b0;
            st.current_page      = '0;
            st.page_sequence_on  = 1'b0;
            st.last_refresh_time = now;
            redraw = 1'b1;
         end

         // Track level changes for the debounce timer
         if (pressed != st.button_last_pressed) begin
            st.button_changed_time = now;
            st.button_last_pressed = pressed;
         end

         // Debounced press: count fast clicks, then enter the special screen or advance one page
         if (pressed && (now - st.button_changed_time) >= {16'd0, cfg.debounce_ms} &&
             !st.press_handled) begin
            st.press_handled = 1'b1;
            if (st.fast_click_count == '0 ||
                (now - st.click_window_start) > {16'd0, cfg.click_window_ms}) begin
               st.click_window_start = now;
               st.fast_click_count   = 3'd1;
            end else begin
               st.fast_click_count = st.fast_click_count + 3'd1;
            end

            if (st.fast_click_count >= cfg.click_target) begin
               st.fast_click_count = '0;
               st.special_active   = 1'b1;
               st.special_until    = now + {16'd0, cfg.special_hold_ms};
               st.page_sequence_on = 1'b0;
               st.current_page     = '0;
               expected_screens.push_back(shown_screen(1'b1));
               return;
            end

            if (!st.page_sequence_on) begin
               st.page_sequence_on = 1'b1;
               next_page = 4'd1;
            end else begin
               next_page = {1'b0, st.current_page} + 4'd1;
               if (next_page >= cfg.page_count || next_page > LastPage) begin
                  next_page = 4'd0;
                  st.page_sequence_on = 1'b0;
               end
            end
            st.current_page      = next_page[PageWidth-1:0];
            st.page_shown_time   = now;
            st.last_refresh_time = now;
            redraw = 1'b1;
         end

         if (!pressed)
            st.press_handled = 1'b0;

         // Extra page timed out: back to main
         if (st.page_sequence_on && (now - st.page_shown_time) >= cfg.page_interval_ms) begin
            st.current_page      = '0;
            st.page_sequence_on  = 1'b0;
            st.last_refresh_time = now;
            redraw = 1'b1;
         end

         // First draw and periodic refresh of main
         if (!st.page_sequence_on &&
             (st.first_main_pending || (now - st.last_refresh_time) >= cfg.page_interval_ms)) begin
            st.first_main_pending = 1'b0;
            st.last_refresh_time  = now;
            st.current_page       = '0;
            redraw = 1'b1;
         end

         expected_screens.push_back(shown_screen(redraw));
      endfunction

      function void compare_field(string field, int unsigned want, int unsigned got);
         if (want != got) begin
            mismatches++;
            if (mismatches <= 10)
               $display("screen %0d: %s expected %0d, got %0d", screens_seen, field, want, got);
         end
      endfunction

      // Check a returned screen update against the oldest prediction
      function void check_result(result_type got);
         result_type want;
         if (expected_screens.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("screen %0d: update with no sample outstanding", screens_seen);
         end else begin
            want = expected_screens.pop_front();
            compare_field("redraw", 32'(want.redraw), 32'(got.redraw));
            compare_field("page_index", 32'(want.page_index), 32'(got.page_index));
            compare_field("special_shown", 32'(want.special_shown),
                          32'(got.special_shown));
            compare_field("sequence_active", 32'(want.sequence_active),
                          32'(got.sequence_active));
         end
         screens_seen++;
      endfunction
   endclass

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    req_valid;
   logic                    req_ready;
   logic [TimeWidth-1:0]    req_now_ms;
   logic                    req_button_pressed;
   logic                    rsp_valid;
   logic                    rsp_ready;
   logic                    rsp_redraw;
   logic [PageWidth-1:0]    rsp_page_index;
   logic                    rsp_special_shown;
   logic                    rsp_sequence_active;
   logic                    csr_write_enable;
   logic [CsrIdxWidth-1:0]  csr_index;
   logic [CsrDataWidth-1:0] csr_write_data;

   page_scoreboard sb = new();

   int unsigned          tx_idle_pct = 29;
   int unsigned          rx_idle_pct = 45;
   int unsigned          samples_sent = 0;
   logic [TimeWidth-1:0] t_now = '0;

   button_page_selector u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_now_ms          (req_now_ms),
      .req_button_pressed  (req_button_pressed),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_redraw          (rsp_redraw),
      .rsp_page_index      (rsp_page_index),
      .rsp_special_shown   (rsp_special_shown),
      .rsp_sequence_active (rsp_sequence_active),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data)
   );

   always #5 clock = ~clock;

   // Stall the result channel at random
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
   end

   // Check every result transfer
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result('{rsp_redraw, rsp_page_index, rsp_special_shown, rsp_sequence_active});
   end

   // Offer one sample and hold it until the transfer
   task automatic send_item(input logic [TimeWidth-1:0] now, input logic pressed);
      if (samples_sent < 250) begin
         tx_idle_pct = 29;
         rx_idle_pct = 45;
      end else if (samples_sent < 500) begin
         tx_idle_pct = 45;
         rx_idle_pct = 29;
      end else begin
         tx_idle_pct = 0;
         rx_idle_pct = 0;
      end
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_now_ms         <= now;
      req_button_pressed <= pressed;
      do @(posedge clock); while (!req_ready);
      sb.note_sample(now, pressed);
      samples_sent++;
   endtask

   // Drop valid and wait until every expected screen has come back
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CsrIdxWidth-1:0] idx,
                            input logic [CsrDataWidth-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
      sb.write_reg(idx, data);
   endtask

   // Release, press, then hold past the debounce time (or just short of it)
   task automatic press_once(input logic [TimeWidth-1:0] gap, input bit clean);
      logic [TimeWidth-1:0] settle;
      settle = {16'd0, sb.cfg.debounce_ms} + (clean ? 0 : $urandom_range(0, 3));
      if (!clean && $urandom_range(4) == 0 && sb.cfg.debounce_ms != 0)
         settle = {16'd0, sb.cfg.debounce_ms} - 1;
      t_now += gap;
      send_item(t_now, 1'b0);
      t_now += $urandom_range(1, 5);
      send_item(t_now, 1'b1);
      if (!clean && $urandom_range(3) == 0) begin
         // contact bounce restarts the debounce timer
         t_now += $urandom_range(0, 3);
         send_item(t_now, 1'b0);
         t_now += $urandom_range(0, 3);
         send_item(t_now, 1'b1);
      end
      t_now += settle;
      send_item(t_now, 1'b1);
   endtask

   // Mostly well-formed press trains, with timed gaps and some noise
   task automatic random_traffic(input int unsigned count);
      int unsigned          kind;
      int unsigned          stop_at;
      logic [TimeWidth-1:0] span;
      stop_at = samples_sent + count;
      while (samples_sent < stop_at) begin
         kind = $urandom_range(99);
         if (kind < 55) begin
            // fast clicks, mostly inside the click window
            span = sb.cfg.click_window_ms / 4 + 8;
            repeat ($urandom_range(1, 8))
               press_once($urandom_range(0, span), 1'($urandom_range(1)));
         end else if (kind < 72) begin
            // land on the page timeout or refresh boundary
            press_once(sb.cfg.page_interval_ms + $urandom_range(0, 4) - 2,
                       1'($urandom_range(1)));
         end else if (kind < 88) begin
            // released samples stepping across hold expiry and refresh
            repeat ($urandom_range(1, 4)) begin
               if ($urandom_range(1))
                  t_now += $urandom_range(0, sb.cfg.special_hold_ms / 2 + 50);
               else
                  t_now += sb.cfg.page_interval_ms + $urandom_range(0, 2) - 1;
               send_item(t_now, 1'b0);
            end
         end else if (kind < 94) begin
            // random level at small steps
            repeat ($urandom_range(1, 6)) begin
               t_now += $urandom_range(0, 60);
               send_item(t_now, 1'($urandom_range(1)));
            end
         end else begin
            // jump to any timestamp
            t_now = $urandom();
            send_item(t_now, 1'($urandom_range(1)));
         end
      end
      drain();
   endtask

   task automatic random_config();
      write_csr(CsrPageInterval, ($urandom_range(9) == 0) ? $urandom() : $urandom_range(50, 20000));
      write_csr(CsrPageCount,   $urandom_range(0, 15));
      write_csr(CsrDebounce,    $urandom_range(0, 200));
      write_csr(CsrClickWindow, $urandom_range(0, 5000));
      write_csr(CsrClickTarget, $urandom_range(0, 7));
      write_csr(CsrSpecialHold, $urandom_range(0, 8000));
   endtask

   initial begin
      reset              <= 1'b1;
      req_valid          <= 1'b0;
      req_now_ms         <= '0;
      req_button_pressed <= 1'b0;
      rsp_ready          <= 1'b0;
      csr_write_enable   <= 1'b0;
      csr_index          <= '0;
      csr_write_data     <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Display not ready after reset: samples change nothing
      send_item(32'd0, 1'b1);
      send_item(32'd30, 1'b0);
      drain();

      // Short page cycle, then fast clicks into the special screen
      write_csr(CsrDisplayReady, 32'd1);
      write_csr(CsrPageCount, 32'd3);
      t_now = 32'd1000;
      send_item(t_now, 1'b0);
      repeat (5) press_once(32'd60, 1'b1);
      // held screen ignores a released sample, then expires exactly on time
      t_now += {16'd0, sb.cfg.special_hold_ms} - 1;
      send_item(t_now, 1'b0);
      t_now += 1;
      send_item(t_now, 1'b1);
      drain();

      // Reset-value settings
      write_csr(CsrPageCount, {28'd0, RstPageCount});
      random_traffic(150);

      // One page only, zero times everywhere
      write_csr(CsrPageCount,   32'd1);
      write_csr(CsrClickTarget, 32'd7);
      write_csr(CsrDebounce,    32'd0);
      write_csr(CsrClickWindow, 32'd0);
      write_csr(CsrSpecialHold, 32'd0);
      write_csr(CsrPageInterval, 32'd0);
      random_traffic(60);

      // No pages and a zero click target
      write_csr(CsrPageCount,   32'd0);
      write_csr(CsrClickTarget, 32'd0);
      write_csr(CsrPageInterval, 32'd3000);
      write_csr(CsrSpecialHold, 32'd200);
      write_csr(CsrDebounce,    32'd25);
      random_traffic(40);

      // Largest values, crossing the timestamp wrap
      write_csr(CsrPageCount,    32'd15);
      write_csr(CsrClickTarget,  32'd7);
      write_csr(CsrDebounce,     32'h0000_FFFF);
      write_csr(CsrClickWindow,  32'h0000_FFFF);
      write_csr(CsrSpecialHold,  32'h0000_FFFF);
      write_csr(CsrPageInterval, 32'hFFFF_FFFF);
      t_now = 32'hFFFF_0000;
      random_traffic(100);

      // Display switched off, then on but not ready
      write_csr(CsrDisplayEnabled, 32'd0);
      repeat (15) begin
         t_now += $urandom_range(0, 100);
         send_item(t_now, 1'($urandom_range(1)));
      end
      drain();
      write_csr(CsrDisplayEnabled, 32'd1);
      write_csr(CsrDisplayReady, 32'd0);
      repeat (8) begin
         t_now += $urandom_range(0, 100);
         send_item(t_now, 1'($urandom_range(1)));
      end
      drain();
      write_csr(CsrDisplayReady, 32'd1);

      // Random settings
      repeat (4) begin
         random_config();
         random_traffic(90);
      end

      drain();
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   // Give up on a hung run
   initial begin
      #5000000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

`default_nettype wire
